@@ src/msfs_pkg.sv @@
// Package for the media file signature sniffer: format codes, command codes,
// header geometry and MPEG frame header masks. No dependencies.
`default_nettype none

package msfs_pkg;

    // Header geometry.
    localparam int HEAD_BYTES = 15;
    localparam int LEN_W      = 5;
    localparam int CODE_W     = 5;

    // Check group selection carried by the command field.
    typedef enum logic [1:0] {
        CMD_ALL     = 2'd0,
        CMD_PICTURE = 2'd1,
        CMD_AUDVID  = 2'd2,
        CMD_TAG     = 2'd3
    } cmd_t;

    // Result format codes.
    localparam logic [CODE_W-1:0] FMT_NONE   = 5'd0;
    localparam logic [CODE_W-1:0] FMT_JPEG   = 5'd1;
    localparam logic [CODE_W-1:0] FMT_GIF    = 5'd2;
    localparam logic [CODE_W-1:0] FMT_ICO    = 5'd3;
    localparam logic [CODE_W-1:0] FMT_PNG    = 5'd4;
    localparam logic [CODE_W-1:0] FMT_PSD    = 5'd5;
    localparam logic [CODE_W-1:0] FMT_TIFF   = 5'd6;
    localparam logic [CODE_W-1:0] FMT_BMP    = 5'd7;
    localparam logic [CODE_W-1:0] FMT_OGG    = 5'd8;
    localparam logic [CODE_W-1:0] FMT_FLAC   = 5'd9;
    localparam logic [CODE_W-1:0] FMT_WAV    = 5'd10;
    localparam logic [CODE_W-1:0] FMT_AIFF   = 5'd11;
    localparam logic [CODE_W-1:0] FMT_MPEG   = 5'd12;
    localparam logic [CODE_W-1:0] FMT_ID3V2  = 5'd13;
    localparam logic [CODE_W-1:0] FMT_APEV2  = 5'd14;
    localparam logic [CODE_W-1:0] FMT_ID3V1  = 5'd15;
    localparam logic [CODE_W-1:0] FMT_VORBIS = 5'd16;
    localparam logic [CODE_W-1:0] FMT_LAST   = FMT_VORBIS;

    // MPEG audio frame header fields, on bytes 0..3 taken big-endian.
    localparam logic [31:0] MPEG_SYNC_MASK    = 32'hffe00000;
    localparam logic [31:0] MPEG_VER_MASK     = 32'h00180000;
    localparam logic [31:0] MPEG_VER_RESERVED = 32'h00080000;
    localparam logic [31:0] MPEG_LAYER_MASK   = 32'h00060000;
    localparam logic [31:0] MPEG_RATE_MASK    = 32'h0000f000;

    // Header byte array.
    typedef logic [7:0] head_t [HEAD_BYTES];

endpackage

`default_nettype wire

@@ src/media_file_signature_sniffer.sv @@
// An accepted transaction is held in the input register, then passes to the result register on the m_ side.
// Throughput: one header per cycle, set by the input register feeding the result
// register through the combinational classifier; stalls propagate back through ready.
// Reset: synchronous active-low aresetn clears both stage valid flags; no sweep is needed.
// Depends on msfs_pkg and msfs_classify.
`default_nettype none

module media_file_signature_sniffer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_command,
    input  wire logic [63:0]                  s_head_low,
    input  wire logic [55:0]                  s_head_high,
    input  wire logic [msfs_pkg::LEN_W-1:0]   s_available_length,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [msfs_pkg::CODE_W-1:0]  m_format_code
);
    import msfs_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    cmd_t                 command_reg;
    logic [63:0]          head_low_reg;
    logic [55:0]          head_high_reg;
    logic [LEN_W-1:0]     length_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CODE_W-1:0]    code_reg;
    logic [CODE_W-1:0]    code_next;
    logic                 out_ready;

    // Each stage advances when the stage after it is empty or draining.
    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = out_ready ? in_valid_reg : out_valid_reg;

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register captures each accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            command_reg   <= cmd_t'(s_command);
            head_low_reg  <= s_head_low;
            head_high_reg <= s_head_high;
            length_reg    <= s_available_length;
        end
    end

    // Classifier between the input and result registers.
    msfs_classify u_classify (
        .command          (command_reg),
        .head_low         (head_low_reg),
        .head_high        (head_high_reg),
        .available_length (length_reg),
        .format_code      (code_next)
    );

    // Result register holds until the result transaction completes.
    always_ff @(posedge aclk) begin
        if (out_ready && in_valid_reg) begin
            code_reg <= code_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_format_code = code_reg;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !in_valid_reg))
        else $error("pipeline not empty after reset");

    // An accepted transaction lands in the input register.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted transaction lost at input register");

    // A held input item moves to the result register when it has room.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready) |=> m_valid)
        else $error("input item did not reach result register");

    // Result codes stay within the defined formats.
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_format_code <= FMT_LAST))
        else $error("format code out of range");

endmodule

`default_nettype wire

@@ src/msfs_classify.sv @@
// Combinational signature classifier for one registered header.
// Depends on msfs_pkg for the codes, masks and the header byte array type.
`default_nettype none

module msfs_classify (
    input  wire msfs_pkg::cmd_t               command,
    input  wire logic [63:0]                  head_low,
    input  wire logic [55:0]                  head_high,
    input  wire logic [msfs_pkg::LEN_W-1:0]   available_length,
    output logic      [msfs_pkg::CODE_W-1:0]  format_code
);
    import msfs_pkg::*;

    head_t                b;
    logic [31:0]          w;
    logic [CODE_W-1:0]    pic_code;
    logic [CODE_W-1:0]    av_code;
    logic [CODE_W-1:0]    tag_code;
    logic                 len3, len4, len8, len10, len12, len15;

    // Split the two header words into bytes, byte 0 in the low bits.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            b[i] = head_low[8*i +: 8];
        end
        for (int i = 0; i < 7; i++) begin
            b[8+i] = head_high[8*i +: 8];
        end
    end

    // Minimum length qualifiers; a zero length fails all of them.
    assign len3  = (available_length >= LEN_W'(3));
    assign len4  = (available_length >= LEN_W'(4));
    assign len8  = (available_length >= LEN_W'(8));
    assign len10 = (available_length >= LEN_W'(10));
    assign len12 = (available_length >= LEN_W'(12));
    assign len15 = (available_length >= LEN_W'(15));

    assign w = {b[0], b[1], b[2], b[3]};

    // Picture group, first match in priority order.
    always_comb begin
        pic_code = FMT_NONE;
        if (len10 && b[0] == 8'hff && b[1] == 8'hd8 &&
            ({b[6], b[7], b[8], b[9]} == "JFIF" || {b[6], b[7], b[8], b[9]} == "Exif")) begin
            pic_code = FMT_JPEG;
        end else if (len4 && {b[0], b[1], b[2], b[3]} == "GIF8") begin
            pic_code = FMT_GIF;
        end else if (len4 && {b[0], b[1], b[2], b[3]} == 32'h00000100) begin
            pic_code = FMT_ICO;
        end else if (len8 && b[0] == 8'h89 && {b[1], b[2], b[3]} == "PNG" &&
                     {b[4], b[5], b[6], b[7]} == 32'h0d0a1a0a) begin
            pic_code = FMT_PNG;
        end else if (len4 && {b[0], b[1], b[2], b[3]} == "8BPS") begin
            pic_code = FMT_PSD;
        end else if (len4 && ({b[0], b[1], b[2], b[3]} == {"MM", 16'h002a} ||
                              {b[0], b[1], b[2], b[3]} == {"II", 16'h2a00})) begin
            pic_code = FMT_TIFF;
        end else if (len15 && {b[0], b[1]} == "BM" &&
                     (b[14] == 8'd12 || b[14] == 8'd64 ||
                      b[14] == 8'd40 || b[14] == 8'd128)) begin
            pic_code = FMT_BMP;
        end
    end

    // Audio/video group, first match in priority order.
    always_comb begin
        av_code = FMT_NONE;
        if (len4 && {b[0], b[1], b[2], b[3]} == "OggS") begin
            av_code = FMT_OGG;
        end else if (len4 && {b[0], b[1], b[2], b[3]} == "fLaC") begin
            av_code = FMT_FLAC;
        end else if (len12 && {b[0], b[1], b[2], b[3]} == "RIFF" &&
                     {b[8], b[9], b[10], b[11]} == "WAVE") begin
            av_code = FMT_WAV;
        end else if (len12 && {b[0], b[1], b[2], b[3]} == "FORM" &&
                     {b[8], b[9], b[10], b[11]} == "AIFF") begin
            av_code = FMT_AIFF;
        end else if (len4 && (w & MPEG_SYNC_MASK) == MPEG_SYNC_MASK &&
                     (w & MPEG_VER_MASK) != MPEG_VER_RESERVED &&
                     (w & MPEG_LAYER_MASK) != 32'h0 &&
                     (w & MPEG_RATE_MASK) != MPEG_RATE_MASK) begin
            av_code = FMT_MPEG;
        end
    end

    // Tag group, first match in priority order.
    always_comb begin
        tag_code = FMT_NONE;
        if (len3 && ({b[0], b[1], b[2]} == "ID3" || {b[0], b[1], b[2]} == "3DI")) begin
            tag_code = FMT_ID3V2;
        end else if (len8 && {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} == "APETAGEX") begin
            tag_code = FMT_APEV2;
        end else if (len3 && {b[0], b[1], b[2]} == "TAG") begin
            tag_code = FMT_ID3V1;
        end else if (len8 && {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]} == "VORBCOMM") begin
            tag_code = FMT_VORBIS;
        end
    end

    // Group selection; the full run takes the first group with a match.
    always_comb begin
        case (command)
            CMD_PICTURE: format_code = pic_code;
            CMD_AUDVID:  format_code = av_code;
            CMD_TAG:     format_code = tag_code;
            default: begin
                if (pic_code != FMT_NONE) begin
                    format_code = pic_code;
                end else if (av_code != FMT_NONE) begin
                    format_code = av_code;
                end else begin
                    format_code = tag_code;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for media_file_signature_sniffer: directed header table, then
// random signatures and noise under random idling and a long result stall.
// Depends on msfs_pkg and the media_file_signature_sniffer RTL.
`timescale 1ns / 1ps

module testbench;
    import msfs_pkg::*;

    // Kinds of well-formed signatures planted into random headers.
    typedef enum int {
        SIG_JFIF, SIG_EXIF, SIG_GIF, SIG_ICO, SIG_PNG, SIG_PSD, SIG_TIFF_MM, SIG_TIFF_II,
        SIG_BMP, SIG_OGG, SIG_FLAC, SIG_WAV, SIG_AIFF, SIG_MPEG, SIG_ID3, SIG_ID3_FOOTER,
        SIG_APE, SIG_TAG, SIG_VORBIS, SIG_COUNT
    } signature_t;

    // One directed header; a typed code is used instead of the predictor when set.
    typedef struct {
        cmd_t              cmd;
        logic [119:0]      hdr;
        logic [LEN_W-1:0]  len;
        bit                typed;
        logic [CODE_W-1:0] code;
    } probe_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_command;
    logic [63:0]         s_head_low;
    logic [55:0]         s_head_high;
    logic [LEN_W-1:0]    s_available_length;
    logic                m_valid;
    logic                m_ready;
    logic [CODE_W-1:0]   m_format_code;

    logic [CODE_W-1:0]   expected_formats[$];
    probe_t              directed_probes[$];
    int                  mismatch_count = 0;
    int                  result_count = 0;
    bit                  idling_on = 1'b1;
    bit                  hold_off_request = 1'b0;
    int                  hold_left = 0;

    media_file_signature_sniffer u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_head_low        (s_head_low),
        .s_head_high       (s_head_high),
        .s_available_length(s_available_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_format_code     (m_format_code)
    );

    // Free-running clock, 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Header building: byte i of the header sits in bits 8*i+7..8*i.
    function automatic logic [119:0] put_text(logic [119:0] h, int pos, string s);
        for (int i = 0; i < s.len(); i++) h[8*(pos+i) +: 8] = s[i];
        return h;
    endfunction

    function automatic logic [119:0] put_be(logic [119:0] h, int pos, logic [31:0] w, int n);
        for (int i = 0; i < n; i++) h[8*(pos+i) +: 8] = w[31-8*i -: 8];
        return h;
    endfunction

    function automatic logic [119:0] random_header();
        logic [119:0] h;
        h[31:0]   = $urandom;
        h[63:32]  = $urandom;
        h[95:64]  = $urandom;
        h[119:96] = 24'($urandom);
        return h;
    endfunction

    // Classifier: byte comparisons per check group, first match in group order wins.
    function automatic bit text_at(head_t b, int pos, string s);
        for (int i = 0; i < s.len(); i++) begin
            if (pos + i >= HEAD_BYTES || b[pos+i] != s[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [CODE_W-1:0] sniff_picture(head_t b, logic [LEN_W-1:0] len);
        if (len == 0) return FMT_NONE;
        if (len >= 10 && b[0] == 8'hff && b[1] == 8'hd8 &&
            (text_at(b, 6, "JFIF") || text_at(b, 6, "Exif"))) return FMT_JPEG;
        if (len >= 4 && text_at(b, 0, "GIF8")) return FMT_GIF;
        if (len >= 4 && b[0] == 8'h00 && b[1] == 8'h00 && b[2] == 8'h01 && b[3] == 8'h00)
            return FMT_ICO;
        if (len >= 8 && b[0] == 8'h89 && text_at(b, 1, "PNG") && b[4] == 8'h0d &&
            b[5] == 8'h0a && b[6] == 8'h1a && b[7] == 8'h0a) return FMT_PNG;
        if (len >= 4 && text_at(b, 0, "8BPS")) return FMT_PSD;
        if (len >= 4 && text_at(b, 0, "MM") && b[2] == 8'h00 && b[3] == 8'h2a) return FMT_TIFF;
        if (len >= 4 && text_at(b, 0, "II") && b[2] == 8'h2a && b[3] == 8'h00) return FMT_TIFF;
        if (len >= 15 && text_at(b, 0, "BM") && (b[14] == 8'd12 || b[14] == 8'd64 ||
            b[14] == 8'd40 || b[14] == 8'd128)) return FMT_BMP;
        return FMT_NONE;
    endfunction

    function automatic logic [CODE_W-1:0] sniff_audvid(head_t b, logic [LEN_W-1:0] len);
        logic [31:0] w;
        w = {b[0], b[1], b[2], b[3]};
        if (len == 0) return FMT_NONE;
        if (len >= 4 && text_at(b, 0, "OggS")) return FMT_OGG;
        if (len >= 4 && text_at(b, 0, "fLaC")) return FMT_FLAC;
        if (len >= 12 && text_at(b, 0, "RIFF") && text_at(b, 8, "WAVE")) return FMT_WAV;
        if (len >= 12 && text_at(b, 0, "FORM") && text_at(b, 8, "AIFF")) return FMT_AIFF;
        if (len >= 4 && (w & MPEG_SYNC_MASK) == MPEG_SYNC_MASK &&
            (w & MPEG_VER_MASK) != MPEG_VER_RESERVED && (w & MPEG_LAYER_MASK) != 32'd0 &&
            (w & MPEG_RATE_MASK) != MPEG_RATE_MASK) return FMT_MPEG;
        return FMT_NONE;
    endfunction

    function automatic logic [CODE_W-1:0] sniff_tag(head_t b, logic [LEN_W-1:0] len);
        if (len == 0) return FMT_NONE;
        if (len >= 3 && (text_at(b, 0, "ID3") || text_at(b, 0, "3DI"))) return FMT_ID3V2;
        if (len >= 8 && text_at(b, 0, "APETAGEX")) return FMT_APEV2;
        if (len >= 3 && text_at(b, 0, "TAG")) return FMT_ID3V1;
        if (len >= 8 && text_at(b, 0, "VORBCOMM")) return FMT_VORBIS;
        return FMT_NONE;
    endfunction

    function automatic logic [CODE_W-1:0] sniff_format(cmd_t cmd, logic [119:0] hdr,
                                                       logic [LEN_W-1:0] len);
        head_t             b;
        logic [CODE_W-1:0] code;
        for (int i = 0; i < HEAD_BYTES; i++) b[i] = hdr[8*i +: 8];
        case (cmd)
            CMD_PICTURE: code = sniff_picture(b, len);
            CMD_AUDVID:  code = sniff_audvid(b, len);
            CMD_TAG:     code = sniff_tag(b, len);
            default: begin
                code = sniff_picture(b, len);
                if (code == FMT_NONE) code = sniff_audvid(b, len);
                if (code == FMT_NONE) code = sniff_tag(b, len);
            end
        endcase
        return code;
    endfunction

    // Overlay a well-formed signature on a header, keeping the other bytes.
    function automatic logic [119:0] plant_signature(signature_t sig, logic [119:0] h);
        logic [31:0] w;
        logic [7:0]  dib_size;
        case (sig)
            SIG_JFIF:       h = put_text(put_be(h, 0, 32'hffd80000, 2), 6, "JFIF");
            SIG_EXIF:       h = put_text(put_be(h, 0, 32'hffd80000, 2), 6, "Exif");
            SIG_GIF:        h = put_text(h, 0, "GIF8");
            SIG_ICO:        h = put_be(h, 0, 32'h00000100, 4);
            SIG_PNG:        h = put_be(put_be(h, 0, 32'h89504e47, 4), 4, 32'h0d0a1a0a, 4);
            SIG_PSD:        h = put_text(h, 0, "8BPS");
            SIG_TIFF_MM:    h = put_be(h, 0, 32'h4d4d002a, 4);
            SIG_TIFF_II:    h = put_be(h, 0, 32'h49492a00, 4);
            SIG_BMP: begin
                case ($urandom_range(0, 4))
                    0:       dib_size = 8'd12;
                    1:       dib_size = 8'd64;
                    2:       dib_size = 8'd40;
                    3:       dib_size = 8'd128;
                    default: dib_size = 8'($urandom);
                endcase
                h = put_be(put_text(h, 0, "BM"), 14, {dib_size, 24'h0}, 1);
            end
            SIG_OGG:        h = put_text(h, 0, "OggS");
            SIG_FLAC:       h = put_text(h, 0, "fLaC");
            SIG_WAV:        h = put_text(put_text(h, 0, "RIFF"), 8, "WAVE");
            SIG_AIFF:       h = put_text(put_text(h, 0, "FORM"), 8, "AIFF");
            SIG_MPEG: begin
                // Sync forced; version, layer and bitrate left random.
                w = $urandom;
                w[31:21] = '1;
                h = put_be(h, 0, w, 4);
            end
            SIG_ID3:        h = put_text(h, 0, "ID3");
            SIG_ID3_FOOTER: h = put_text(h, 0, "3DI");
            SIG_APE:        h = put_text(h, 0, "APETAGEX");
            SIG_TAG:        h = put_text(h, 0, "TAG");
            default:        h = put_text(h, 0, "VORBCOMM");
        endcase
        return h;
    endfunction

    function automatic void add_probe(cmd_t cmd, logic [119:0] hdr, logic [LEN_W-1:0] len,
                                      bit typed, logic [CODE_W-1:0] code);
        probe_t p;
        p.cmd   = cmd;
        p.hdr   = hdr;
        p.len   = len;
        p.typed = typed;
        p.code  = code;
        directed_probes.push_back(p);
    endfunction

    // Offer one header transaction after random idle cycles; record its code on acceptance.
    task automatic offer_header(cmd_t cmd, logic [119:0] hdr, logic [LEN_W-1:0] len,
                                logic [CODE_W-1:0] code);
        while (idling_on && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_command          <= cmd;
        s_head_low         <= hdr[63:0];
        s_head_high        <= hdr[119:64];
        s_available_length <= len;
        do @(posedge aclk); while (!s_ready);
        expected_formats.push_back(code);
    endtask

    // Result side: random stalls, plus one long hold-off counted here.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(idling_on && $urandom_range(0, 99) < 28);
            end
        end
    end

    // Compare each accepted result with the oldest expected code.
    always @(posedge aclk) begin
        logic [CODE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_formats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d: unexpected transaction, format_code %0d",
                             result_count, m_format_code);
            end else begin
                want = expected_formats.pop_front();
                if (m_format_code !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: format_code expected %0d, got %0d",
                                 result_count, want, m_format_code);
                end
            end
            result_count++;
        end
    end

    // Stimulus: reset, directed table, random headers, drain.
    initial begin
        cmd_t             cmd;
        logic [119:0]     hdr;
        logic [LEN_W-1:0] len;

        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_command          = '0;
        s_head_low         = '0;
        s_head_high        = '0;
        s_available_length = '0;

        // Extremes, every check, every command, and the length corner cases.
        add_probe(CMD_ALL, put_text('0, 0, "GIF8"), 0, 1, FMT_NONE);
        add_probe(CMD_ALL, '1, 31, 1, FMT_NONE);
        add_probe(CMD_ALL, '0, 31, 1, FMT_NONE);
        add_probe(CMD_PICTURE, plant_signature(SIG_JFIF, '0), 10, 1, FMT_JPEG);
        add_probe(CMD_ALL, plant_signature(SIG_EXIF, '0), 9, 0, FMT_NONE);
        add_probe(CMD_ALL, plant_signature(SIG_EXIF, '0), 10, 1, FMT_JPEG);
        add_probe(CMD_PICTURE, plant_signature(SIG_GIF, '0), 4, 1, FMT_GIF);
        add_probe(CMD_PICTURE, plant_signature(SIG_GIF, '0), 3, 0, FMT_NONE);
        add_probe(CMD_PICTURE, plant_signature(SIG_ICO, '0), 4, 1, FMT_ICO);
        add_probe(CMD_ALL, plant_signature(SIG_PNG, '0), 8, 1, FMT_PNG);
        add_probe(CMD_PICTURE, plant_signature(SIG_PSD, '0), 4, 1, FMT_PSD);
        add_probe(CMD_PICTURE, plant_signature(SIG_TIFF_MM, '0), 4, 1, FMT_TIFF);
        add_probe(CMD_ALL, plant_signature(SIG_TIFF_II, '0), 4, 1, FMT_TIFF);
        add_probe(CMD_PICTURE, put_be(put_text('0, 0, "BM"), 14, 32'h28000000, 1), 15, 1,
                  FMT_BMP);
        // BMP needs byte 14, which lies past a length of 14.
        add_probe(CMD_PICTURE, put_be(put_text('0, 0, "BM"), 14, 32'h80000000, 1), 14, 0,
                  FMT_NONE);
        add_probe(CMD_AUDVID, plant_signature(SIG_OGG, '0), 4, 1, FMT_OGG);
        add_probe(CMD_AUDVID, plant_signature(SIG_FLAC, '0), 31, 1, FMT_FLAC);
        add_probe(CMD_ALL, plant_signature(SIG_WAV, '0), 12, 1, FMT_WAV);
        add_probe(CMD_AUDVID, plant_signature(SIG_AIFF, '0), 12, 1, FMT_AIFF);
        add_probe(CMD_AUDVID, put_be('0, 0, 32'hfffb9000, 4), 4, 1, FMT_MPEG);
        add_probe(CMD_AUDVID, put_be('0, 0, 32'hffeb9000, 4), 4, 0, FMT_NONE);
        add_probe(CMD_TAG, plant_signature(SIG_ID3, '0), 3, 1, FMT_ID3V2);
        add_probe(CMD_TAG, plant_signature(SIG_ID3_FOOTER, '0), 3, 1, FMT_ID3V2);
        add_probe(CMD_ALL, plant_signature(SIG_APE, '0), 8, 1, FMT_APEV2);
        add_probe(CMD_TAG, plant_signature(SIG_TAG, '0), 3, 1, FMT_ID3V1);
        add_probe(CMD_TAG, plant_signature(SIG_VORBIS, '0), 8, 1, FMT_VORBIS);
        add_probe(CMD_PICTURE, plant_signature(SIG_OGG, '0), 4, 1, FMT_NONE);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_probes[i]) begin
            offer_header(directed_probes[i].cmd, directed_probes[i].hdr, directed_probes[i].len,
                         directed_probes[i].typed ? directed_probes[i].code :
                         sniff_format(directed_probes[i].cmd, directed_probes[i].hdr,
                                      directed_probes[i].len));
        end

        // Mostly planted signatures with random surroundings, some corrupted, rest noise.
        for (int n = 0; n < 1100; n++) begin
            if (n == 250) hold_off_request = 1'b1;
            idling_on = !(n >= 500 && n < 700);
            hdr = random_header();
            cmd = cmd_t'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 70) begin
                if ($urandom_range(0, 99) < 40) cmd = CMD_ALL;
                hdr = plant_signature(signature_t'($urandom_range(0, SIG_COUNT - 1)), hdr);
                if ($urandom_range(0, 99) < 15) hdr[$urandom_range(0, 95)] ^= 1'b1;
                len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 15)) :
                                                    LEN_W'($urandom_range(15, 31));
            end else begin
                len = LEN_W'($urandom_range(0, 31));
            end
            offer_header(cmd, hdr, len, sniff_format(cmd, hdr, len));
        end
        s_valid <= 1'b0;
        idling_on = 1'b1;

        // Drain outstanding results, then allow for the pipeline depth.
        while (expected_formats.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** media_file_signature_sniffer: PASSED **");
        end else begin
            $display("** media_file_signature_sniffer: FAILED **");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("** media_file_signature_sniffer: FAILED **");
        $finish;
    end

endmodule
